// ===== hdl/lcfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes for the layer cadence filament resolver.
package lcfr_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int MAX_PATTERN  = 32;
    localparam int MAX_PHYSICAL = 16;
    localparam int MAX_RATIO    = 127;

    localparam int EIDX_W = $clog2(MAX_ENTRIES);
    localparam int POS_W  = $clog2(MAX_PATTERN);
    localparam int PADDR_W = EIDX_W + POS_W;
    localparam int DVD_W  = 28;
    localparam int DVS_W  = 8;

    // Command codes
    localparam logic [1:0] CMD_WRITE_ENTRY = 2'd0;
    localparam logic [1:0] CMD_WRITE_STEP  = 2'd1;
    localparam logic [1:0] CMD_RESOLVE     = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_PHYS   = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_GRAD   = 2'd2;
    localparam logic [1:0] REG_DITHER = 2'd3;

    localparam logic [4:0] PHYS_RESET = 5'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  entry_index;
        logic [4:0]  comp_a;
        logic [4:0]  comp_b;
        logic [6:0]  ratio_a;
        logic [6:0]  ratio_b;
        logic [2:0]  entry_flags;
        logic [5:0]  pattern_len;
        logic [4:0]  step_pos;
        logic [3:0]  step_value;
        logic [6:0]  req_id;
        logic [19:0] layer_num;
    } in_word_t;

    typedef struct packed {
        logic [6:0] physical_id;
        logic       was_virtual;
    } out_word_t;

    typedef struct packed {
        logic [4:0] comp_a;
        logic [4:0] comp_b;
        logic [6:0] ratio_a;
        logic [6:0] ratio_b;
        logic [2:0] flags;
        logic [5:0] plen;
    } entry_t;

    typedef enum logic [1:0] {
        K_WRITE_ENTRY,
        K_WRITE_STEP,
        K_RESOLVE,
        K_IGNORE
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        in_word_t word;
    } q_item_t;

    // Effective (saturated) configuration handed to the back end
    typedef struct packed {
        logic [4:0] nphys;
        logic [6:0] ncount;
        logic       gradient;
        logic       dither;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HIT,
        S_PDIV,
        S_PRD,
        S_PRES,
        S_SDIV,
        S_DDIV,
        S_GCD,
        S_GCDDIV,
        S_MUL,
        S_PHST,
        S_PHDIV,
        S_PMUL,
        S_RST,
        S_RDIV
    } state_t;

endpackage

// ===== hdl/lcfr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts command words, classifies them and queues them.
module lcfr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lcfr_pkg::in_word_t cmd_data,
    output logic               q_valid,
    output lcfr_pkg::q_item_t  q_item,
    input  logic               q_pop
);
    import lcfr_pkg::*;

    q_item_t    q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    q_item_t    item;
    logic       push;

    // Classify and saturate the pattern length
    always_comb
    begin
        item      = '{kind: K_IGNORE, word: cmd_data};
        case (cmd_data.cmd)
            CMD_WRITE_ENTRY: item.kind = K_WRITE_ENTRY;
            CMD_WRITE_STEP:  item.kind = K_WRITE_STEP;
            CMD_RESOLVE:     item.kind = K_RESOLVE;
            default:         item.kind = K_IGNORE;
        endcase
        if (cmd_data.pattern_len > 6'(MAX_PATTERN))
            item.word.pattern_len = 6'(MAX_PATTERN);
    end

    assign cmd_ready = (cnt_reg != 2'd2);
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= item;
    end

endmodule

// ===== hdl/lcfr_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
module lcfr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lcfr_pkg::DVD_W-1:0] dividend,
    input  logic [lcfr_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [lcfr_pkg::DVD_W-1:0] quot,
    output logic [lcfr_pkg::DVS_W-1:0] rem
);
    import lcfr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] r_reg, r_next;
    logic [DVS_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             ge;

    // One restoring step
    always_comb
    begin
        trial     = {r_reg, q_reg[DVD_W-1]};
        ge        = (trial >= {1'b0, d_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            q_next    = {q_reg[DVD_W-2:0], ge};
            r_next    = ge ? DVS_W'(trial - {1'b0, d_reg}) : trial[DVS_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ===== hdl/lcfr_back.sv =====
`timescale 1ns / 1ps
// Back end: entry and pattern stores, entry scan and cadence sequencer.
module lcfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lcfr_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  lcfr_pkg::q_item_t   q_item,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output lcfr_pkg::out_word_t res_data
);
    import lcfr_pkg::*;

    entry_t     ent_mem [MAX_ENTRIES];
    logic [3:0] pat_mem [MAX_ENTRIES * MAX_PATTERN];
    entry_t     ent_rd_reg;
    logic [3:0] pat_rd_reg;

    state_t     state_reg, state_next;
    in_word_t   word_reg, word_next;
    entry_t     ent_reg, ent_next;
    logic [6:0] tgt_reg, tgt_next;
    logic [6:0] seen_reg, seen_next;
    logic [6:0] idx_reg, idx_next;
    logic [7:0] pos_reg, pos_next;
    logic [19:0] cidx_reg, cidx_next;
    logic [8:0] s_reg, s_next;
    logic [8:0] ga_reg, ga_next;
    logic [7:0] gb_reg, gb_next;
    logic [7:0] step_reg, step_next;
    logic [DVD_W-1:0] prod_reg, prod_next;
    logic [7:0] p_reg, p_next;
    logic [PADDR_W-1:0] paddr_reg, paddr_next;
    logic       out_v_reg, out_v_next;
    out_word_t  out_reg, out_next;

    logic       div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_quot;
    logic [DVS_W-1:0] div_dvs, div_rem;

    logic       take, emit;
    out_word_t  emit_word;
    logic       ent_we, pat_we;
    logic [7:0] cyc;
    logic       usable, dmode;
    logic [8:0] psum, s_half;
    logic [4:0] pres;

    lcfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign cyc    = 8'(ent_reg.ratio_a) + 8'(ent_reg.ratio_b);
    assign dmode  = !cfg.gradient && cfg.dither && ent_reg.flags[2];
    assign usable = ent_rd_reg.flags[0] && !ent_rd_reg.flags[1];
    assign take   = q_valid && (!out_v_reg || res_ready);
    assign psum   = 9'(pos_reg) + 9'(div_rem);
    assign s_half = 9'(cyc[7:1]) + 9'd1;

    // Pattern step selection
    always_comb
    begin
        pres = 5'd0;
        if (pat_rd_reg == 4'd1)
            pres = ent_reg.comp_a;
        else if (pat_rd_reg == 4'd2)
            pres = ent_reg.comp_b;
        else if (pat_rd_reg >= 4'd3 && pat_rd_reg <= 4'd9 && 5'(pat_rd_reg) <= cfg.nphys)
            pres = 5'(pat_rd_reg);
        if (pres < 5'd1 || pres > cfg.nphys)
            pres = ent_reg.comp_a;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (take && q_item.kind == K_RESOLVE
                    && q_item.word.req_id > 7'(cfg.nphys))
                    state_next = S_SCAN_RD;
            S_SCAN_RD:
                state_next = (idx_reg >= cfg.ncount) ? S_IDLE : S_SCAN_CHK;
            S_SCAN_CHK:
                state_next = (usable && seen_reg == tgt_reg) ? S_HIT : S_SCAN_RD;
            S_HIT:
                if (ent_reg.plen != 6'd0)
                    state_next = S_PDIV;
                else if (cyc == 8'd0)
                    state_next = S_IDLE;
                else if (dmode)
                    state_next = (ent_reg.ratio_a == 7'd0 || ent_reg.ratio_b == 7'd0)
                                 ? S_IDLE : S_DDIV;
                else
                    state_next = S_SDIV;
            S_PDIV:   if (div_done) state_next = S_PRD;
            S_PRD:    state_next = S_PRES;
            S_PRES:   state_next = S_IDLE;
            S_SDIV:   if (div_done) state_next = S_IDLE;
            S_DDIV:   if (div_done) state_next = S_GCD;
            S_GCD:
                if (gb_reg == 8'd0)
                begin
                    if (ga_reg == 9'd1)
                        state_next = S_MUL;
                end
                else
                    state_next = S_GCDDIV;
            S_GCDDIV: if (div_done) state_next = S_GCD;
            S_MUL:    state_next = S_PHST;
            S_PHST:   state_next = S_PHDIV;
            S_PHDIV:  if (div_done) state_next = S_PMUL;
            S_PMUL:   state_next = S_RST;
            S_RST:    state_next = S_RDIV;
            S_RDIV:   if (div_done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Strobes: queue pop, store writes, divider starts, result emission
    always_comb
    begin
        q_pop     = 1'b0;
        ent_we    = 1'b0;
        pat_we    = 1'b0;
        emit      = 1'b0;
        emit_word = '0;
        div_start = 1'b0;
        div_dvd   = DVD_W'(word_reg.layer_num);
        div_dvs   = cyc;
        case (state_reg)
            S_IDLE:
                if (take)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        K_WRITE_ENTRY: begin ent_we = 1'b1; emit = 1'b1; end
                        K_WRITE_STEP:  begin pat_we = 1'b1; emit = 1'b1; end
                        K_RESOLVE:
                            if (q_item.word.req_id <= 7'(cfg.nphys))
                            begin
                                emit                  = 1'b1;
                                emit_word.physical_id = q_item.word.req_id;
                            end
                        default: emit = 1'b1;
                    endcase
                end
            S_SCAN_RD:
                if (idx_reg >= cfg.ncount)
                begin
                    emit                  = 1'b1;
                    emit_word.physical_id = word_reg.req_id;
                end
            S_HIT:
            begin
                emit_word.was_virtual = 1'b1;
                if (ent_reg.plen != 6'd0)
                begin
                    div_start = 1'b1;
                    div_dvs   = 8'(ent_reg.plen);
                end
                else if (cyc == 8'd0)
                begin
                    emit                  = 1'b1;
                    emit_word.physical_id = 7'(ent_reg.comp_a);
                end
                else if (dmode && ent_reg.ratio_b == 7'd0)
                begin
                    emit                  = 1'b1;
                    emit_word.physical_id = 7'(ent_reg.comp_a);
                end
                else if (dmode && ent_reg.ratio_a == 7'd0)
                begin
                    emit                  = 1'b1;
                    emit_word.physical_id = 7'(ent_reg.comp_b);
                end
                else
                    div_start = 1'b1;
            end
            S_PRES:
            begin
                emit                  = 1'b1;
                emit_word.was_virtual = 1'b1;
                emit_word.physical_id = 7'(pres);
            end
            S_SDIV:
                if (div_done)
                begin
                    emit                  = 1'b1;
                    emit_word.was_virtual = 1'b1;
                    emit_word.physical_id = (div_rem < 8'(ent_reg.ratio_a))
                                            ? 7'(ent_reg.comp_a) : 7'(ent_reg.comp_b);
                end
            S_GCD:
                if (gb_reg != 8'd0)
                begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(ga_reg);
                    div_dvs   = gb_reg;
                end
            S_PHST:
            begin
                div_start = 1'b1;
                div_dvd   = prod_reg;
            end
            S_RST:
            begin
                div_start = 1'b1;
                div_dvd   = prod_reg;
            end
            S_RDIV:
                if (div_done)
                begin
                    emit                  = 1'b1;
                    emit_word.was_virtual = 1'b1;
                    emit_word.physical_id = (9'(div_rem) + 9'(ent_reg.ratio_b) >= 9'(cyc))
                                            ? 7'(ent_reg.comp_b) : 7'(ent_reg.comp_a);
                end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        word_next  = word_reg;
        ent_next   = ent_reg;
        tgt_next   = tgt_reg;
        seen_next  = seen_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        cidx_next  = cidx_reg;
        s_next     = s_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        p_next     = p_reg;
        paddr_next = paddr_reg;
        out_v_next = (out_v_reg && !res_ready) || emit;
        out_next   = emit ? emit_word : out_reg;
        case (state_reg)
            S_IDLE:
                if (take)
                begin
                    word_next = q_item.word;
                    tgt_next  = q_item.word.req_id - 7'(cfg.nphys) - 7'd1;
                    seen_next = 7'd0;
                    idx_next  = 7'd0;
                end
            S_SCAN_CHK:
                if (usable && seen_reg == tgt_reg)
                    ent_next = ent_rd_reg;
                else
                begin
                    idx_next = idx_reg + 7'd1;
                    if (usable)
                        seen_next = seen_reg + 7'd1;
                end
            S_PDIV:
                paddr_next = {idx_reg[EIDX_W-1:0], div_rem[POS_W-1:0]};
            S_DDIV:
                if (div_done)
                begin
                    pos_next  = div_rem;
                    cidx_next = div_quot[19:0];
                    s_next    = s_half;
                    ga_next   = s_half;
                    gb_next   = cyc;
                end
            S_GCD:
                if (gb_reg == 8'd0)
                begin
                    if (ga_reg == 9'd1)
                        step_next = (s_reg >= 9'(cyc)) ? 8'(s_reg - 9'(cyc)) : 8'(s_reg);
                    else
                    begin
                        s_next  = s_reg + 9'd1;
                        ga_next = s_reg + 9'd1;
                        gb_next = cyc;
                    end
                end
            S_GCDDIV:
                if (div_done)
                begin
                    ga_next = 9'(gb_reg);
                    gb_next = div_rem;
                end
            S_MUL:
                prod_next = DVD_W'(cidx_reg) * DVD_W'(step_reg);
            S_PHDIV:
                if (div_done)
                    p_next = (psum >= 9'(cyc)) ? 8'(psum - 9'(cyc)) : 8'(psum);
            S_PMUL:
                prod_next = DVD_W'(p_reg) * DVD_W'(ent_reg.ratio_b);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        ent_reg   <= ent_next;
        tgt_reg   <= tgt_next;
        seen_reg  <= seen_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        cidx_reg  <= cidx_next;
        s_reg     <= s_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        step_reg  <= step_next;
        prod_reg  <= prod_next;
        p_reg     <= p_next;
        paddr_reg <= paddr_next;
        out_reg   <= out_next;
    end

    // Entry table
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[q_item.word.entry_index] <= '{comp_a:  q_item.word.comp_a,
                                                  comp_b:  q_item.word.comp_b,
                                                  ratio_a: q_item.word.ratio_a,
                                                  ratio_b: q_item.word.ratio_b,
                                                  flags:   q_item.word.entry_flags,
                                                  plen:    q_item.word.pattern_len};
        ent_rd_reg <= ent_mem[idx_reg[EIDX_W-1:0]];
    end

    // Pattern store
    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[{q_item.word.entry_index, q_item.word.step_pos}] <= q_item.word.step_value;
        pat_rd_reg <= pat_mem[paddr_reg];
    end

    assign res_valid = out_v_reg;
    assign res_data  = out_reg;

endmodule

// ===== hdl/layer_cadence_filament_resolver.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, front queue and resolve back end.
// Writes, ignored commands and physical ids: queued, then the result word is registered,
// one word per cycle sustained while res_ready holds. Virtual id: dequeue, then a read
// and a check state per scanned entry, then a divider pass per division: one for a
// pattern or a plain split, three for dither plus one per gcd step.
// Reset (rst_n, async low) clears registers, queue and output; stores keep no reset value.
module layer_cadence_filament_resolver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  lcfr_pkg::in_word_t  cmd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output lcfr_pkg::out_word_t res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lcfr_pkg::*;

    logic [4:0] phys_reg;
    logic [6:0] count_reg;
    logic       grad_reg;
    logic       dither_reg;
    logic       wr_en;
    cfg_t       cfg;
    logic       q_valid, q_pop;
    q_item_t    q_item;

    // Register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phys_reg   <= PHYS_RESET;
            count_reg  <= 7'd0;
            grad_reg   <= 1'b0;
            dither_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_PHYS:   phys_reg   <= pwdata[4:0];
                REG_COUNT:  count_reg  <= pwdata[6:0];
                REG_GRAD:   grad_reg   <= pwdata[0];
                REG_DITHER: dither_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PHYS:   prdata = 32'(phys_reg);
            REG_COUNT:  prdata = 32'(count_reg);
            REG_GRAD:   prdata = 32'(grad_reg);
            REG_DITHER: prdata = 32'(dither_reg);
            default:    prdata = 32'd0;
        endcase
    end

    // Saturated view of the registers
    assign cfg.nphys    = (phys_reg > 5'(MAX_PHYSICAL)) ? 5'(MAX_PHYSICAL) : phys_reg;
    assign cfg.ncount   = (count_reg > 7'(MAX_ENTRIES)) ? 7'(MAX_ENTRIES) : count_reg;
    assign cfg.gradient = grad_reg;
    assign cfg.dither   = dither_reg;

    lcfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    lcfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// ===== hdl/lcfr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the resolver, bound to the top level.
module lcfr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input lcfr_pkg::out_word_t res_data
);
    import lcfr_pkg::*;

    // A stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    // A word from a table entry carries a component id of at most five bits
    a_virt_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.was_virtual |-> res_data.physical_id < 7'd32)
        else $error("table result out of component range");

    // Nothing is pending right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid out of reset");

endmodule

bind layer_cadence_filament_resolver lcfr_checker u_lcfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
